// ----- hw/rtl/owbm_pkg.sv -----
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants for the one-wire bus master core.
// ----------------------------------------------------------------------------
package owbm_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_W         = $clog2(BITS_PER_BYTE);
	localparam int TICK_W        = 10;
	localparam int CFG_DATA_W    = 10;
	localparam int CFG_IDX_W     = 3;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

	// register reset values
	localparam logic [9:0] RESET_LOW_DEF      = 10'd300;
	localparam logic [7:0] PRESENCE_WAIT_DEF  = 8'd40;
	localparam logic [9:0] RESET_RECOVERY_DEF = 10'd500;
	localparam logic [5:0] SLOT_START_DEF     = 6'd7;
	localparam logic [7:0] WRITE_ZERO_DEF     = 8'd63;
	localparam logic [5:0] READ_SAMPLE_DEF    = 6'd7;
	localparam logic [9:0] SLOT_RECOVERY_DEF  = 10'd250;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_RESET = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_RST_REC  = 3'd3,
		PH_SLOT_LOW = 3'd4,
		PH_SLOT_REL = 3'd5,
		PH_SLOT_REC = 3'd6
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RESET_LOW      = 3'd0,
		CFG_PRESENCE_WAIT  = 3'd1,
		CFG_RESET_RECOVERY = 3'd2,
		CFG_SLOT_START     = 3'd3,
		CFG_WRITE_ZERO     = 3'd4,
		CFG_READ_SAMPLE    = 3'd5,
		CFG_SLOT_RECOVERY  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] write_byte;
		logic       line_level;
	} in_item_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_byte;
	} out_item_t;

	// classified tick handed from front to back
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] write_byte;
		logic       line_level;
	} tick_t;

	typedef struct packed {
		logic [9:0] reset_low_time;
		logic [7:0] presence_wait_time;
		logic [9:0] reset_recovery_time;
		logic [5:0] slot_start_time;
		logic [7:0] write_zero_extra_time;
		logic [5:0] read_sample_delay;
		logic [9:0] slot_recovery_time;
	} cfg_regs_t;

endpackage

// ----- hw/rtl/owbm_front.sv -----
// ----------------------------------------------------------------------------
// owbm_front
// Accepts tick beats, decodes the action into a command class and holds the
// result in one stage register until the queue takes it.
// ----------------------------------------------------------------------------
module owbm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  owbm_pkg::in_item_t in_data,
	output logic               push,
	input  logic               push_ready,
	output owbm_pkg::tick_t    push_data
);

	logic            valid_s1;
	owbm_pkg::tick_t item_s1;
	owbm_pkg::tick_t item_dec;

	// classify the incoming beat
	always_comb begin
		item_dec.cmd        = owbm_pkg::cmd_t'(in_data.action);
		item_dec.write_byte = in_data.write_byte;
		item_dec.line_level = in_data.line_level;
	end

	assign push      = valid_s1;
	assign push_data = item_s1;
	assign in_ready  = !valid_s1 || push_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_dec;
		end
	end

endmodule

// ----- hw/rtl/owbm_queue.sv -----
// ----------------------------------------------------------------------------
// owbm_queue
// Small FIFO of classified ticks between front and back.
// ----------------------------------------------------------------------------
module owbm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            push_ready,
	input  owbm_pkg::tick_t push_data,
	output logic            pop_valid,
	input  logic            pop,
	output owbm_pkg::tick_t pop_data
);

	owbm_pkg::tick_t                 mem_q [owbm_pkg::QUEUE_DEPTH];
	logic [owbm_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [owbm_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [owbm_pkg::QUEUE_AW:0]     count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = count_q != (owbm_pkg::QUEUE_AW+1)'(owbm_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/owbm_back.sv -----
// ----------------------------------------------------------------------------
// owbm_back
// Bus sequencer: runs reset, write and read slots one tick per beat and
// registers the result beat for the output channel.
// ----------------------------------------------------------------------------
module owbm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  owbm_pkg::cfg_regs_t cfg,
	input  logic                pop_valid,
	output logic                pop,
	input  owbm_pkg::tick_t     pop_data,
	output logic                out_valid,
	input  logic                out_ready,
	output owbm_pkg::out_item_t out_data
);

	localparam int TW = owbm_pkg::TICK_W;
	localparam int BW = owbm_pkg::BIT_W;

	owbm_pkg::phase_t    phase_q, phase_d, ph;
	owbm_pkg::cmd_t      kind_q, kind;
	logic [TW-1:0]       tick_q, tick_d, tick;
	logic [BW-1:0]       bit_q, bit_d, bidx;
	logic [7:0]          shift_q, shift_d, shift;
	logic                presence_q, presence_d;
	logic [7:0]          result_q, result_d;
	logic [TW-1:0]       len;
	logic [TW-1:0]       start1;
	logic                last;
	logic                done;
	logic                slot_end;
	logic                rec_entry;
	logic                out_valid_q;
	owbm_pkg::out_item_t out_q;

	assign pop       = pop_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign start1 = (cfg.slot_start_time == '0) ? TW'(1) : TW'(cfg.slot_start_time);

	// command pickup, phase length and tick step
	always_comb begin
		ph         = phase_q;
		kind       = kind_q;
		tick       = tick_q;
		bidx       = bit_q;
		shift      = shift_q;
		presence_d = presence_q;
		result_d   = result_q;
		done       = 1'b0;
		slot_end   = 1'b0;
		rec_entry  = 1'b0;

		if (phase_q == owbm_pkg::PH_IDLE && pop_data.cmd != owbm_pkg::CMD_NONE) begin
			kind = pop_data.cmd;
			tick = '0;
			bidx = '0;
			if (pop_data.cmd == owbm_pkg::CMD_RESET) begin
				ph = owbm_pkg::PH_RST_LOW;
			end else begin
				shift = (pop_data.cmd == owbm_pkg::CMD_WRITE) ? pop_data.write_byte : 8'h00;
				ph    = owbm_pkg::PH_SLOT_LOW;
			end
		end

		case (ph)
			owbm_pkg::PH_RST_LOW: begin
				len = (cfg.reset_low_time == '0) ? TW'(1) : cfg.reset_low_time;
			end
			owbm_pkg::PH_RST_WAIT: begin
				len = (cfg.presence_wait_time == '0) ? TW'(1) : TW'(cfg.presence_wait_time);
			end
			owbm_pkg::PH_RST_REC: begin
				len = cfg.reset_recovery_time;
			end
			owbm_pkg::PH_SLOT_LOW: begin
				// a written zero holds the bus low for the extra time
				if (kind == owbm_pkg::CMD_WRITE && !shift[bidx]) begin
					len = start1 + TW'(cfg.write_zero_extra_time);
				end else begin
					len = start1;
				end
			end
			owbm_pkg::PH_SLOT_REL: begin
				len = (cfg.read_sample_delay == '0) ? TW'(1) : TW'(cfg.read_sample_delay);
			end
			owbm_pkg::PH_SLOT_REC: begin
				len = cfg.slot_recovery_time;
			end
			default: begin
				len = '0;
			end
		endcase

		last = ({1'b0, tick} + (TW+1)'(1)) >= {1'b0, len};

		// samples on the last tick of the waiting phases
		if (last && ph == owbm_pkg::PH_RST_WAIT) begin
			presence_d = !pop_data.line_level;
		end
		if (last && ph == owbm_pkg::PH_SLOT_REL) begin
			shift = {pop_data.line_level, shift[7:1]};
		end

		phase_d = ph;
		tick_d  = last ? '0 : tick + 1'b1;
		bit_d   = bidx;

		// phase advance, zero-length recovery phases are skipped
		if (last) begin
			case (ph)
				owbm_pkg::PH_RST_LOW: begin
					phase_d = owbm_pkg::PH_RST_WAIT;
				end
				owbm_pkg::PH_RST_WAIT: begin
					if (cfg.reset_recovery_time != '0) begin
						phase_d = owbm_pkg::PH_RST_REC;
					end else begin
						phase_d = owbm_pkg::PH_IDLE;
						done    = 1'b1;
					end
				end
				owbm_pkg::PH_SLOT_LOW: begin
					if (kind == owbm_pkg::CMD_READ) begin
						phase_d = owbm_pkg::PH_SLOT_REL;
					end else begin
						rec_entry = 1'b1;
					end
				end
				owbm_pkg::PH_SLOT_REL: begin
					rec_entry = 1'b1;
				end
				owbm_pkg::PH_SLOT_REC: begin
					slot_end = 1'b1;
				end
				default: begin
					phase_d = owbm_pkg::PH_IDLE;
					done    = (ph != owbm_pkg::PH_IDLE);
				end
			endcase
		end

		if (rec_entry) begin
			if (cfg.slot_recovery_time != '0) begin
				phase_d = owbm_pkg::PH_SLOT_REC;
			end else begin
				slot_end = 1'b1;
			end
		end

		// end of a bit slot: next bit or command complete
		if (slot_end) begin
			if (bidx == BW'(owbm_pkg::BITS_PER_BYTE - 1)) begin
				if (kind == owbm_pkg::CMD_READ) begin
					result_d = shift;
				end
				phase_d = owbm_pkg::PH_IDLE;
				bit_d   = '0;
				done    = 1'b1;
			end else begin
				bit_d   = bidx + 1'b1;
				phase_d = owbm_pkg::PH_SLOT_LOW;
			end
		end

		shift_d = shift;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= owbm_pkg::PH_IDLE;
			kind_q     <= owbm_pkg::CMD_NONE;
			tick_q     <= '0;
			bit_q      <= '0;
			shift_q    <= '0;
			presence_q <= 1'b0;
			result_q   <= '0;
		end else if (pop) begin
			phase_q    <= (ph == owbm_pkg::PH_IDLE) ? owbm_pkg::PH_IDLE : phase_d;
			kind_q     <= kind;
			tick_q     <= (ph == owbm_pkg::PH_IDLE) ? tick_q : tick_d;
			bit_q      <= bit_d;
			shift_q    <= shift_d;
			presence_q <= presence_d;
			result_q   <= result_d;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.drive_low <= (ph == owbm_pkg::PH_RST_LOW) || (ph == owbm_pkg::PH_SLOT_LOW);
			out_q.busy_res  <= (ph != owbm_pkg::PH_IDLE);
			out_q.done_res  <= done;
			out_q.presence  <= presence_d;
			out_q.read_byte <= result_d;
		end
	end

endmodule

// ----- hw/rtl/one_wire_bus_master_core.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master_core
// One-wire bus master: each beat is one microsecond tick of bus time.
// Path: a tick beat passes the front stage, the queue and the sequencer
//   output register. Throughput: one tick per cycle unless out_ready stalls,
//   set by the single-tick sequencer step.
// Reset: timing registers return to their defaults, sequencer goes idle,
//   queue and stages empty; no clearing pass.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  owbm_pkg::in_item_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output owbm_pkg::out_item_t                   out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [owbm_pkg::CFG_DATA_W-1:0]       cfg_data
);

	owbm_pkg::cfg_regs_t cfg_q;
	logic                push;
	logic                push_ready;
	owbm_pkg::tick_t     push_data;
	logic                pop_valid;
	logic                pop;
	owbm_pkg::tick_t     pop_data;

	assign cfg_ready = 1'b1;

	// timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time        <= owbm_pkg::RESET_LOW_DEF;
			cfg_q.presence_wait_time    <= owbm_pkg::PRESENCE_WAIT_DEF;
			cfg_q.reset_recovery_time   <= owbm_pkg::RESET_RECOVERY_DEF;
			cfg_q.slot_start_time       <= owbm_pkg::SLOT_START_DEF;
			cfg_q.write_zero_extra_time <= owbm_pkg::WRITE_ZERO_DEF;
			cfg_q.read_sample_delay     <= owbm_pkg::READ_SAMPLE_DEF;
			cfg_q.slot_recovery_time    <= owbm_pkg::SLOT_RECOVERY_DEF;
		end else if (cfg_valid) begin
			case (owbm_pkg::cfg_idx_t'(cfg_index))
				owbm_pkg::CFG_RESET_LOW:      cfg_q.reset_low_time        <= cfg_data;
				owbm_pkg::CFG_PRESENCE_WAIT:  cfg_q.presence_wait_time    <= cfg_data[7:0];
				owbm_pkg::CFG_RESET_RECOVERY: cfg_q.reset_recovery_time   <= cfg_data;
				owbm_pkg::CFG_SLOT_START:     cfg_q.slot_start_time       <= cfg_data[5:0];
				owbm_pkg::CFG_WRITE_ZERO:     cfg_q.write_zero_extra_time <= cfg_data[7:0];
				owbm_pkg::CFG_READ_SAMPLE:    cfg_q.read_sample_delay     <= cfg_data[5:0];
				owbm_pkg::CFG_SLOT_RECOVERY:  cfg_q.slot_recovery_time    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	owbm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	owbm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	owbm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- hw/rtl/owbm_checker.sv -----
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks on the one-wire bus master core, bound to the top level.
// ----------------------------------------------------------------------------
module owbm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input owbm_pkg::out_item_t out_data
);

	// a completion beat belongs to a command
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> out_data.busy_res)
		else $error("done beat without busy");

	// the bus is only pulled low inside a command
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drive_low |-> out_data.busy_res)
		else $error("bus driven low while idle");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

endmodule

bind one_wire_bus_master_core owbm_checker u_owbm_checker (.*);

// ----- tb/one_wire_bus_master_core_tb.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master_core_tb
// Self-checking bench for the one-wire bus master core. Tick beats come from
// a queue filled by the stimulus process. Each accepted tick runs through a
// local model of the bus sequencer, and every result beat is checked field
// by field against the oldest predicted tick. Timing registers are programmed
// between phases while the sequencer is idle: all zero, then a series of
// short random settings with random handshake gaps.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core_tb;

	localparam int PIPE_LATENCY = 2;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 150;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_TICKS  = 100;

	// line level modes for generated ticks
	localparam int LINE_LOW  = 0;
	localparam int LINE_HIGH = 1;
	localparam int LINE_RAND = 2;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	owbm_pkg::in_item_t              in_data   = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	owbm_pkg::out_item_t             out_data;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	one_wire_bus_master_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// ticks waiting to be sent, and predicted result beats
	owbm_pkg::in_item_t  bus_tick_q[$];
	owbm_pkg::out_item_t expected_bus_q[$];
	int        mismatch_count = 0;
	int        queued_ticks   = 0;
	int        idle_mode      = 0;
	int        hold_req       = 0;
	int        hold_ack       = 0;
	int        hold_left      = 0;
	int        quiet_cycles   = 0;
	logic      in_taken       = 1'b0;

	// ------------------------------------------------------------------------
	// Sequencer model state
	// ------------------------------------------------------------------------
	owbm_pkg::cfg_regs_t timing;
	owbm_pkg::phase_t    ph;
	owbm_pkg::cmd_t      cmd_kind;
	logic [9:0]          tick_cnt;
	logic [2:0]          bit_idx;
	logic [7:0]          shreg;
	logic                pres;
	logic [7:0]          rd_byte;

	function automatic int unsigned floor_one(int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	// length of the current phase in ticks
	function automatic int unsigned phase_ticks();
		case (ph)
			owbm_pkg::PH_RST_LOW:  return floor_one(timing.reset_low_time);
			owbm_pkg::PH_RST_WAIT: return floor_one(timing.presence_wait_time);
			owbm_pkg::PH_RST_REC:  return timing.reset_recovery_time;
			owbm_pkg::PH_SLOT_LOW: begin
				if (cmd_kind == owbm_pkg::CMD_WRITE && !shreg[bit_idx])
					return floor_one(timing.slot_start_time) +
						timing.write_zero_extra_time;
				return floor_one(timing.slot_start_time);
			end
			owbm_pkg::PH_SLOT_REL: return floor_one(timing.read_sample_delay);
			owbm_pkg::PH_SLOT_REC: return timing.slot_recovery_time;
			default:               return 0;
		endcase
	endfunction

	// step past a finished phase, skipping empty ones; 1 when the command ends
	function automatic bit next_phase();
		while (1'b1) begin
			tick_cnt = '0;
			case (ph)
				owbm_pkg::PH_RST_LOW:  ph = owbm_pkg::PH_RST_WAIT;
				owbm_pkg::PH_RST_WAIT: ph = owbm_pkg::PH_RST_REC;
				owbm_pkg::PH_SLOT_LOW: ph = (cmd_kind == owbm_pkg::CMD_READ) ?
					owbm_pkg::PH_SLOT_REL : owbm_pkg::PH_SLOT_REC;
				owbm_pkg::PH_SLOT_REL: ph = owbm_pkg::PH_SLOT_REC;
				owbm_pkg::PH_SLOT_REC: begin
					if (bit_idx == 3'(owbm_pkg::BITS_PER_BYTE - 1)) begin
						if (cmd_kind == owbm_pkg::CMD_READ)
							rd_byte = shreg;
						ph      = owbm_pkg::PH_IDLE;
						bit_idx = '0;
						return 1'b1;
					end
					bit_idx = bit_idx + 3'd1;
					ph      = owbm_pkg::PH_SLOT_LOW;
				end
				default: begin
					ph = owbm_pkg::PH_IDLE;
					return 1'b1;
				end
			endcase
			if (phase_ticks() != 0)
				return 1'b0;
		end
		return 1'b0;
	endfunction

	// one bus tick through the model
	function automatic owbm_pkg::out_item_t predict_bus_tick(owbm_pkg::in_item_t t);
		owbm_pkg::out_item_t r;
		int unsigned         len;
		bit                  last;
		r = '0;
		if (ph == owbm_pkg::PH_IDLE && t.action != owbm_pkg::CMD_NONE) begin
			cmd_kind = owbm_pkg::cmd_t'(t.action);
			tick_cnt = '0;
			bit_idx  = '0;
			if (cmd_kind == owbm_pkg::CMD_RESET) begin
				ph = owbm_pkg::PH_RST_LOW;
			end else begin
				shreg = (cmd_kind == owbm_pkg::CMD_WRITE) ? t.write_byte : 8'h00;
				ph    = owbm_pkg::PH_SLOT_LOW;
			end
		end
		if (ph != owbm_pkg::PH_IDLE) begin
			len         = phase_ticks();
			last        = (int'(tick_cnt) + 1 >= len);
			r.busy_res  = 1'b1;
			r.drive_low = (ph == owbm_pkg::PH_RST_LOW || ph == owbm_pkg::PH_SLOT_LOW);
			if (last && ph == owbm_pkg::PH_RST_WAIT)
				pres = !t.line_level;
			if (last && ph == owbm_pkg::PH_SLOT_REL)
				shreg = {t.line_level, shreg[7:1]};
			tick_cnt = tick_cnt + 10'd1;
			if (last && next_phase())
				r.done_res = 1'b1;
		end
		r.presence  = pres;
		r.read_byte = rd_byte;
		return r;
	endfunction

	// ticks a well-formed command occupies under the current timing
	function automatic int unsigned command_ticks(owbm_pkg::cmd_t c, logic [7:0] b);
		int unsigned n;
		n = 0;
		case (c)
			owbm_pkg::CMD_RESET: n = floor_one(timing.reset_low_time) +
				floor_one(timing.presence_wait_time) + timing.reset_recovery_time;
			owbm_pkg::CMD_WRITE:
				for (int i = 0; i < owbm_pkg::BITS_PER_BYTE; i++)
					n += floor_one(timing.slot_start_time) + timing.slot_recovery_time +
					     (b[i] ? 0 : timing.write_zero_extra_time);
			owbm_pkg::CMD_READ: n = owbm_pkg::BITS_PER_BYTE *
				(floor_one(timing.slot_start_time) +
				floor_one(timing.read_sample_delay) + timing.slot_recovery_time);
			default: n = 1;
		endcase
		return n;
	endfunction

	function automatic bit chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	// ------------------------------------------------------------------------
	// Tick driver: next beat at the falling edge once the last one is taken
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (bus_tick_q.size() > 0 &&
					!chance((idle_mode == 1) ? 47 : (idle_mode == 3) ? 19 : 0)) begin
				in_data  <= bus_tick_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// accepted tick: predict its result beat
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_bus_q.push_back(predict_bus_tick(in_data));
	end

	// result ready: random stalls plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !chance((idle_mode == 2) ? 47 : (idle_mode == 3) ? 19 : 0);
		end
	end

	// result monitor
	always @(posedge clk) begin
		owbm_pkg::out_item_t exp_beat;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bus_q.size() == 0) begin
				$error("result beat with no tick pending: %h", out_data);
				mismatch_count++;
			end else begin
				exp_beat = expected_bus_q.pop_front();
				if (out_data.drive_low !== exp_beat.drive_low) begin
					$error("drive_low expected %0b actual %0b", exp_beat.drive_low, out_data.drive_low);
					mismatch_count++;
				end
				if (out_data.busy_res !== exp_beat.busy_res) begin
					$error("busy_res expected %0b actual %0b", exp_beat.busy_res, out_data.busy_res);
					mismatch_count++;
				end
				if (out_data.done_res !== exp_beat.done_res) begin
					$error("done_res expected %0b actual %0b", exp_beat.done_res, out_data.done_res);
					mismatch_count++;
				end
				if (out_data.presence !== exp_beat.presence) begin
					$error("presence expected %0b actual %0b", exp_beat.presence, out_data.presence);
					mismatch_count++;
				end
				if (out_data.read_byte !== exp_beat.read_byte) begin
					$error("read_byte expected %h actual %h", exp_beat.read_byte, out_data.read_byte);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_tick(logic [1:0] a, logic [7:0] b, int lm);
		owbm_pkg::in_item_t t;
		t.action     = a;
		t.write_byte = b;
		t.line_level = (lm == LINE_RAND) ? 1'($urandom_range(1)) : (lm == LINE_HIGH);
		bus_tick_q.push_back(t);
		queued_ticks++;
	endtask

	// command tick plus fill for its duration; some fill ticks carry stray commands
	task automatic issue(owbm_pkg::cmd_t c, logic [7:0] b, int lm);
		int unsigned n;
		n = command_ticks(c, b);
		push_tick(c, b, lm);
		for (int unsigned i = 1; i < n; i++) begin
			if (chance(12))
				push_tick(2'($urandom_range(3)), 8'($urandom), lm);
			else
				push_tick(owbm_pkg::CMD_NONE, 8'($urandom), lm);
		end
	endtask

	// wait until every tick is sent and checked and the sequencer is idle
	task automatic settle();
		while (1'b1) begin
			while (bus_tick_q.size() != 0 || in_valid || expected_bus_q.size() != 0)
				@(posedge clk);
			if (ph == owbm_pkg::PH_IDLE)
				break;
			repeat (8) push_tick(owbm_pkg::CMD_NONE, 8'($urandom), LINE_RAND);
		end
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(owbm_pkg::cfg_idx_t idx,
			logic [owbm_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			owbm_pkg::CFG_RESET_LOW:      timing.reset_low_time        = val[9:0];
			owbm_pkg::CFG_PRESENCE_WAIT:  timing.presence_wait_time    = val[7:0];
			owbm_pkg::CFG_RESET_RECOVERY: timing.reset_recovery_time   = val[9:0];
			owbm_pkg::CFG_SLOT_START:     timing.slot_start_time       = val[5:0];
			owbm_pkg::CFG_WRITE_ZERO:     timing.write_zero_extra_time = val[7:0];
			owbm_pkg::CFG_READ_SAMPLE:    timing.read_sample_delay     = val[5:0];
			owbm_pkg::CFG_SLOT_RECOVERY:  timing.slot_recovery_time    = val[9:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_timing(logic [9:0] rl, logic [9:0] pw, logic [9:0] rr,
			logic [9:0] ss, logic [9:0] wz, logic [9:0] rs, logic [9:0] sr);
		write_reg(owbm_pkg::CFG_RESET_LOW, rl);
		write_reg(owbm_pkg::CFG_PRESENCE_WAIT, pw);
		write_reg(owbm_pkg::CFG_RESET_RECOVERY, rr);
		write_reg(owbm_pkg::CFG_SLOT_START, ss);
		write_reg(owbm_pkg::CFG_WRITE_ZERO, wz);
		write_reg(owbm_pkg::CFG_READ_SAMPLE, rs);
		write_reg(owbm_pkg::CFG_SLOT_RECOVERY, sr);
	endtask

	// small value with random junk above the register width
	function automatic logic [9:0] noisy(int w, int unsigned v);
		logic [9:0] junk;
		junk = chance(50) ? 10'($urandom) : 10'd0;
		return 10'(v) | ((junk >> w) << w);
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		owbm_pkg::cmd_t c;
		timing.reset_low_time        = owbm_pkg::RESET_LOW_DEF;
		timing.presence_wait_time    = owbm_pkg::PRESENCE_WAIT_DEF;
		timing.reset_recovery_time   = owbm_pkg::RESET_RECOVERY_DEF;
		timing.slot_start_time       = owbm_pkg::SLOT_START_DEF;
		timing.write_zero_extra_time = owbm_pkg::WRITE_ZERO_DEF;
		timing.read_sample_delay     = owbm_pkg::READ_SAMPLE_DEF;
		timing.slot_recovery_time    = owbm_pkg::SLOT_RECOVERY_DEF;
		ph       = owbm_pkg::PH_IDLE;
		cmd_kind = owbm_pkg::CMD_NONE;
		tick_cnt = '0;
		bit_idx  = '0;
		shreg    = '0;
		pres     = 1'b0;
		rd_byte  = '0;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// all zero: counts floored to one, recovery and extra time skipped
		idle_mode = 1;
		program_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		issue(owbm_pkg::CMD_RESET, 8'h00, LINE_LOW);
		issue(owbm_pkg::CMD_RESET, 8'h00, LINE_HIGH);
		issue(owbm_pkg::CMD_WRITE, 8'h00, LINE_RAND);
		issue(owbm_pkg::CMD_WRITE, 8'hFF, LINE_RAND);
		issue(owbm_pkg::CMD_READ, 8'h00, LINE_HIGH);
		issue(owbm_pkg::CMD_READ, 8'h00, LINE_LOW);
		push_tick(owbm_pkg::CMD_NONE, 8'h00, LINE_RAND);
		issue(owbm_pkg::CMD_READ, 8'hFF, LINE_RAND);
		settle();

		// random short timings, mostly well-formed commands
		for (int p = 0; p < RAND_PHASES; p++) begin
			idle_mode = p % 4;
			program_timing(10'($urandom_range(4)), noisy(8, $urandom_range(4)),
				10'($urandom_range(6)), noisy(6, $urandom_range(3)),
				noisy(8, $urandom_range(4)), noisy(6, $urandom_range(3)),
				10'($urandom_range(4)));
			if (p == 2)
				hold_req++;
			queued_ticks = 0;
			while (queued_ticks < PHASE_TICKS) begin
				if (chance(80)) begin
					c = owbm_pkg::cmd_t'($urandom_range(owbm_pkg::CMD_READ,
						owbm_pkg::CMD_RESET));
					issue(c, 8'($urandom), LINE_RAND);
					repeat ($urandom_range(3))
						push_tick(owbm_pkg::CMD_NONE, 8'($urandom), LINE_RAND);
				end else begin
					repeat ($urandom_range(5, 1))
						push_tick(2'($urandom_range(3)), 8'($urandom), LINE_RAND);
				end
			end
			settle();
		end

		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0 && expected_bus_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
